// File: rtl/tesu_pkg.sv
`default_nettype none

package tesu_pkg;

    localparam int DIST_W        = 31;
    localparam int COEF_W        = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic        [DIST_W-1:0] current_dist;
        logic        [DIST_W-1:0] dist_first;
        logic        [DIST_W-1:0] dist_second;
        logic                     new_is_first;
        logic                     either_alive;
        logic        [DIST_W-1:0] edge_to_new;
        logic signed [COEF_W-1:0] coef_second_over_first;
        logic signed [COEF_W-1:0] coef_first_over_second;
        logic signed [COEF_W-1:0] quad_a_neg;
        logic signed [COEF_W-1:0] quad_a_pos;
        logic signed [COEF_W-1:0] quad_c_neg;
        logic signed [COEF_W-1:0] quad_c_pos;
    } in_t;

    typedef struct packed {
        logic [DIST_W-1:0] new_dist;
        logic              triangle_valid;
    } out_t;

    // per-item values carried alongside the solver
    typedef struct packed {
        logic        [DIST_W-1:0] nd0;
        logic                     alive;
        logic        [DIST_W-1:0] base;
        logic        [DIST_W-1:0] w;
        logic signed [COEF_W-1:0] p;
        logic signed [COEF_W-1:0] q;
        logic                     fail;
    } carry_t;

    typedef struct packed {
        carry_t             carry;
        logic signed [30:0] b;
        logic signed [30:0] a;
    } mid_t;

endpackage

`default_nettype wire

// File: rtl/triangle_eikonal_stencil_update.sv
`default_nettype none

// Fast marching local update for one stencil visit per cycle while the pipeline is not
// held. An item accepted on the input channel passes the front stages, the 16-stage
// square root, the divider entry register and its stages, the back stages and the
// output register; the divider resolves four quotient bits per stage. The pipeline takes a new item
// every cycle while a stage of skid space is free, so one item per cycle is sustained as
// long as the output is taken; when the output stalls, the pipeline holds once the skid fills.
// The no-solution distance resets to 0x7FFFFFFF; the user is to write it with cfg_write while
// the block is idle, and the block itself does not enforce this.

module triangle_eikonal_stencil_update #(
    parameter int FRAC_BITS = tesu_pkg::FRAC_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tesu_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output tesu_pkg::out_t      out_data,
    input  wire logic           cfg_write,
    input  wire logic [30:0]    cfg_data
);

    localparam int MID_W   = $bits(tesu_pkg::mid_t);
    localparam int CARRY_W = $bits(tesu_pkg::carry_t);
    localparam int BPS     = 4;
    localparam int DSTG    = (34 + FRAC_BITS + BPS - 1) / BPS;
    localparam int QW      = DSTG * BPS;

    logic [30:0] max_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_dist_reg <= tesu_pkg::DIST_MAX;
        else if (cfg_write)
            max_dist_reg <= cfg_data;
    end

    logic           skid_vld_reg, out_vld_reg;
    tesu_pkg::out_t skid_reg, out_reg;
    logic           en;
    assign en       = !skid_vld_reg;
    assign in_ready = en;

    logic           fr_vld;
    tesu_pkg::mid_t fr_side;
    logic [62:0]    fr_disc;

    tesu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .in_data  (in_data),
        .out_vld  (fr_vld),
        .out_side (fr_side),
        .out_disc (fr_disc)
    );

    logic             sq_vld;
    logic [31:0]      sq_root;
    logic [MID_W-1:0] sq_side_bits;
    tesu_pkg::mid_t   sq_side;

    tesu_sqrt #(.SIDE_W(MID_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (fr_vld),
        .in_x     (fr_disc),
        .in_side  (fr_side),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side_bits)
    );

    assign sq_side = tesu_pkg::mid_t'(sq_side_bits);

    logic signed [33:0] num;
    logic signed [31:0] den;
    assign num = $signed({2'b00, sq_root}) - 34'(sq_side.b);
    assign den = $signed({sq_side.a, 1'b0});

    logic               dv_vld;
    logic [QW-1:0]      dv_quot;
    logic               dv_neg;
    logic [CARRY_W-1:0] dv_side_bits;

    tesu_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (CARRY_W),
        .BPS       (BPS),
        .STAGES    (DSTG),
        .QW        (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sq_vld),
        .in_num   (num),
        .in_den   (den),
        .in_side  (sq_side.carry),
        .out_vld  (dv_vld),
        .out_quot (dv_quot),
        .out_neg  (dv_neg),
        .out_side (dv_side_bits)
    );

    logic           tl_vld;
    tesu_pkg::out_t tl_data;

    tesu_back #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .inf_dist     (max_dist_reg),
        .in_vld       (dv_vld),
        .in_quot      (dv_quot),
        .in_neg       (dv_neg),
        .in_carry     (tesu_pkg::carry_t'(dv_side_bits)),
        .out_vld      (tl_vld),
        .out_data     (tl_data)
    );

    // output register plus one skid entry; the pipeline holds only while the skid is full
    logic pop;
    assign pop = out_vld_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || pop)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= tl_vld;
            end
        end
        else if (tl_vld && en)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || pop)
        begin
            out_reg <= skid_vld_reg ? skid_reg : tl_data;
        end
        else if (tl_vld && en)
        begin
            skid_reg <= tl_data;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// File: rtl/tesu_front.sv
`default_nettype none

module tesu_front #(
    parameter int FRAC_BITS = tesu_pkg::FRAC_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_vld,
    input  wire tesu_pkg::in_t  in_data,
    output logic                out_vld,
    output tesu_pkg::mid_t      out_side,
    output logic [62:0]         out_disc
);

    function automatic logic signed [30:0] sat31(input logic signed [63:0] v);
        logic signed [30:0] r;
        if (v > 64'sd1073741823)
            r = 31'sh3FFF_FFFF;
        else if (v < -64'sd1073741824)
            r = 31'sh4000_0000;
        else
            r = v[30:0];
        return r;
    endfunction

    // stage 1: branch select and edge path
    logic signed [31:0] u;
    logic        [31:0] u_neg;
    logic               swap;
    logic        [31:0] esum;
    logic        [30:0] e;
    tesu_pkg::carry_t   s1_carry_next;

    assign u     = $signed({1'b0, in_data.dist_second}) - $signed({1'b0, in_data.dist_first});
    assign u_neg = -u;
    assign swap  = u[31];
    assign esum  = {1'b0, in_data.new_is_first ? in_data.dist_first : in_data.dist_second}
                 + {1'b0, in_data.edge_to_new};
    assign e     = esum[31] ? tesu_pkg::DIST_MAX : esum[30:0];

    always_comb
    begin
        s1_carry_next.nd0   = (e < in_data.current_dist) ? e : in_data.current_dist;
        s1_carry_next.alive = in_data.either_alive;
        s1_carry_next.base  = swap ? in_data.dist_second : in_data.dist_first;
        s1_carry_next.w     = swap ? u_neg[30:0] : u[30:0];
        s1_carry_next.p     = swap ? in_data.coef_first_over_second
                                   : in_data.coef_second_over_first;
        s1_carry_next.q     = swap ? in_data.coef_second_over_first
                                   : in_data.coef_first_over_second;
        s1_carry_next.fail  = 1'b0;
    end

    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    tesu_pkg::carry_t   s1_carry_reg, s2_carry_reg, s3_carry_reg, s4_carry_reg;
    logic signed [31:0] s1_a_reg, s1_c0_reg, s2_c0_reg;
    logic signed [63:0] s2_wp_reg;
    logic        [61:0] s2_ww_reg;
    logic signed [30:0] s2_a_reg, s3_a_reg, s3_b_reg, s3_c_reg, s4_a_reg, s4_b_reg;
    logic signed [63:0] s4_bb_reg, s4_ac_reg;
    tesu_pkg::mid_t     s5_side_reg;
    logic        [62:0] s5_disc_reg;

    // stage 2: products
    logic signed [63:0] wp;
    logic        [61:0] ww;
    assign wp = 64'($signed({1'b0, s1_carry_reg.w})) * 64'(s1_carry_reg.p);
    assign ww = 62'(s1_carry_reg.w) * 62'(s1_carry_reg.w);

    // stage 3: b and c
    logic signed [63:0] csum;
    assign csum = $signed({2'b00, s2_ww_reg >> FRAC_BITS}) + 64'(s2_c0_reg);

    // stage 5: discriminant
    logic signed [63:0] disc;
    logic               fail;
    tesu_pkg::carry_t   s4_carry_out;
    assign disc = s4_bb_reg - (s4_ac_reg <<< 2);
    assign fail = disc[63] || (s4_a_reg == 31'sd0);

    always_comb
    begin
        s4_carry_out      = s4_carry_reg;
        s4_carry_out.fail = fail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_carry_reg <= s1_carry_next;
            s1_a_reg     <= swap ? in_data.quad_a_neg : in_data.quad_a_pos;
            s1_c0_reg    <= swap ? in_data.quad_c_neg : in_data.quad_c_pos;

            s2_carry_reg <= s1_carry_reg;
            s2_wp_reg    <= wp;
            s2_ww_reg    <= ww;
            s2_a_reg     <= sat31(64'(s1_a_reg));
            s2_c0_reg    <= s1_c0_reg;

            s3_carry_reg <= s2_carry_reg;
            s3_a_reg     <= s2_a_reg;
            s3_b_reg     <= sat31(s2_wp_reg >>> FRAC_BITS);
            s3_c_reg     <= sat31(csum);

            s4_carry_reg <= s3_carry_reg;
            s4_a_reg     <= s3_a_reg;
            s4_b_reg     <= s3_b_reg;
            s4_bb_reg    <= 64'(s3_b_reg) * 64'(s3_b_reg);
            s4_ac_reg    <= 64'(s3_a_reg) * 64'(s3_c_reg);

            s5_side_reg  <= '{carry: s4_carry_out, b: s4_b_reg, a: s4_a_reg};
            s5_disc_reg  <= disc[63] ? 63'd0 : disc[62:0];
        end
    end

    assign out_vld  = s5_vld_reg;
    assign out_side = s5_side_reg;
    assign out_disc = s5_disc_reg;

endmodule

`default_nettype wire

// File: rtl/tesu_sqrt.sv
`default_nettype none

module tesu_sqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [62:0]       in_x,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_vld,
    output logic [31:0]            out_root,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int PER    = 2;
    localparam int STAGES = 32 / PER;

    logic [63:0]       x_reg    [STAGES];
    logic [63:0]       r_reg    [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];
    logic [STAGES-1:0] vld_reg;

    logic [63:0]       x_src    [STAGES];
    logic [63:0]       r_src    [STAGES];
    logic [SIDE_W-1:0] side_src [STAGES];
    logic [STAGES-1:0] vld_src;

    assign x_src[0]    = {1'b0, in_x};
    assign r_src[0]    = 64'd0;
    assign side_src[0] = in_side;
    assign vld_src[0]  = in_vld;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            logic [63:0] x_nx, r_nx;

            if (k > 0)
            begin : g_link
                assign x_src[k]    = x_reg[k-1];
                assign r_src[k]    = r_reg[k-1];
                assign side_src[k] = side_reg[k-1];
                assign vld_src[k]  = vld_reg[k-1];
            end

            // two digit-recurrence steps, bit weight fixed by stage position
            always_comb
            begin
                logic [63:0] xv, rv, bitv, t;
                xv = x_src[k];
                rv = r_src[k];
                for (int j = 0; j < PER; j++)
                begin
                    bitv = 64'd1 << (62 - 2 * (PER * k + j));
                    t    = rv + bitv;
                    if (xv >= t)
                    begin
                        xv = xv - t;
                        rv = (rv >> 1) + bitv;
                    end
                    else
                    begin
                        rv = rv >> 1;
                    end
                end
                x_nx = xv;
                r_nx = rv;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_src[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k]    <= x_nx;
                    r_reg[k]    <= r_nx;
                    side_reg[k] <= side_src[k];
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[STAGES-1];
    assign out_root = r_reg[STAGES-1][31:0];
    assign out_side = side_reg[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/tesu_div.sv
`default_nettype none

module tesu_div #(
    parameter int FRAC_BITS = tesu_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1,
    parameter int BPS       = 4,
    parameter int STAGES    = (34 + FRAC_BITS + BPS - 1) / BPS,
    parameter int QW        = STAGES * BPS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic signed [33:0] in_num,
    input  wire logic signed [31:0] in_den,
    input  wire logic [SIDE_W-1:0]  in_side,
    output logic                    out_vld,
    output logic [QW-1:0]           out_quot,
    output logic                    out_neg,
    output logic [SIDE_W-1:0]       out_side
);

    logic [33:0] num_mag;
    logic [31:0] den_mag;
    assign num_mag = in_num[33] ? 34'(-in_num) : 34'(in_num);
    assign den_mag = in_den[31] ? 32'(-in_den) : 32'(in_den);

    // entry stage: magnitudes, numerator pre-scaled by 2^FRAC_BITS
    logic              e_vld_reg;
    logic [QW-1:0]     e_n_reg;
    logic [31:0]       e_d_reg;
    logic              e_neg_reg;
    logic [SIDE_W-1:0] e_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (en)
            e_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_n_reg    <= QW'(num_mag) << FRAC_BITS;
            e_d_reg    <= den_mag;
            e_neg_reg  <= in_num[33] ^ in_den[31];
            e_side_reg <= in_side;
        end
    end

    logic [32:0]       rem_reg  [STAGES];
    logic [QW-1:0]     nq_reg   [STAGES];
    logic [31:0]       d_reg    [STAGES];
    logic              neg_reg  [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];
    logic [STAGES-1:0] vld_reg;

    logic [32:0]       rem_src  [STAGES];
    logic [QW-1:0]     nq_src   [STAGES];
    logic [31:0]       d_src    [STAGES];
    logic              neg_src  [STAGES];
    logic [SIDE_W-1:0] side_src [STAGES];
    logic [STAGES-1:0] vld_src;

    assign rem_src[0]  = 33'd0;
    assign nq_src[0]   = e_n_reg;
    assign d_src[0]    = e_d_reg;
    assign neg_src[0]  = e_neg_reg;
    assign side_src[0] = e_side_reg;
    assign vld_src[0]  = e_vld_reg;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            logic [32:0]   rem_nx;
            logic [QW-1:0] nq_nx;

            if (k > 0)
            begin : g_link
                assign rem_src[k]  = rem_reg[k-1];
                assign nq_src[k]   = nq_reg[k-1];
                assign d_src[k]    = d_reg[k-1];
                assign neg_src[k]  = neg_reg[k-1];
                assign side_src[k] = side_reg[k-1];
                assign vld_src[k]  = vld_reg[k-1];
            end

            // restoring steps: numerator bits leave at the top, quotient bits enter below
            always_comb
            begin
                logic [32:0]   rv;
                logic [QW-1:0] nv;
                rv = rem_src[k];
                nv = nq_src[k];
                for (int j = 0; j < BPS; j++)
                begin
                    rv = {rv[31:0], nv[QW-1]};
                    nv = nv << 1;
                    if (rv >= {1'b0, d_src[k]})
                    begin
                        rv    = rv - {1'b0, d_src[k]};
                        nv[0] = 1'b1;
                    end
                end
                rem_nx = rv;
                nq_nx  = nv;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_src[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_nx;
                    nq_reg[k]   <= nq_nx;
                    d_reg[k]    <= d_src[k];
                    neg_reg[k]  <= neg_src[k];
                    side_reg[k] <= side_src[k];
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[STAGES-1];
    assign out_quot = nq_reg[STAGES-1];
    assign out_neg  = neg_reg[STAGES-1];
    assign out_side = side_reg[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/tesu_back.sv
`default_nettype none

module tesu_back #(
    parameter int FRAC_BITS = tesu_pkg::FRAC_BITS_DEF,
    parameter int QW        = 52
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [30:0]      inf_dist,
    input  wire logic             in_vld,
    input  wire logic [QW-1:0]    in_quot,
    input  wire logic             in_neg,
    input  wire tesu_pkg::carry_t in_carry,
    output logic                  out_vld,
    output tesu_pkg::out_t        out_data
);

    // stage a: signed root, saturated to 32 bits
    logic signed [31:0] tv;
    always_comb
    begin
        if (!in_neg)
            tv = (in_quot > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(in_quot[31:0]);
        else
            tv = (in_quot > QW'(33'h0_8000_0000)) ? 32'sh8000_0000 : $signed(-in_quot[31:0]);
    end

    logic               a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    tesu_pkg::carry_t   a_carry_reg, b_carry_reg, c_carry_reg;
    logic signed [31:0] a_tv_reg, b_diff_reg;
    logic signed [63:0] b_pt_reg, c_qd_reg, c_lim_reg;
    logic signed [32:0] b_cand_reg;
    logic        [30:0] c_cand_reg;
    logic               c_in1_reg;
    tesu_pkg::out_t     d_out_reg;

    // stage b: first edge product, offset from the far vertex, candidate sum
    logic signed [32:0] dsum;
    logic signed [31:0] diff;
    assign dsum = 33'(a_tv_reg) - $signed({2'b00, a_carry_reg.w});
    assign diff = (dsum < -33'sd2147483648) ? 32'sh8000_0000 : dsum[31:0];

    // stage c: second product, first containment test, clamp
    logic signed [63:0] lim;
    logic        [30:0] cand_clamp;
    assign lim        = $signed(64'(b_carry_reg.w) << (FRAC_BITS + 1));
    assign cand_clamp = b_cand_reg[32] ? 31'd0 :
                        (b_cand_reg[31] ? tesu_pkg::DIST_MAX : b_cand_reg[30:0]);

    // stage d: final selection
    logic        tri_ok;
    logic [30:0] cand;
    tesu_pkg::out_t res;
    assign tri_ok = c_carry_reg.alive && !c_carry_reg.fail && c_in1_reg
                 && (c_qd_reg <= c_lim_reg);
    assign cand   = tri_ok ? c_cand_reg : inf_dist;
    always_comb
    begin
        res.triangle_valid = tri_ok;
        res.new_dist       = (c_carry_reg.alive && cand < c_carry_reg.nd0) ? cand
                                                                           : c_carry_reg.nd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_carry_reg <= in_carry;
            a_tv_reg    <= tv;

            b_carry_reg <= a_carry_reg;
            b_pt_reg    <= 64'(a_carry_reg.p) * 64'(a_tv_reg);
            b_diff_reg  <= diff;
            b_cand_reg  <= $signed({2'b00, a_carry_reg.base}) + 33'(a_tv_reg);

            c_carry_reg <= b_carry_reg;
            c_qd_reg    <= 64'(b_carry_reg.q) * 64'(b_diff_reg);
            c_lim_reg   <= lim;
            c_in1_reg   <= (b_pt_reg <= -lim);
            c_cand_reg  <= cand_clamp;

            d_out_reg   <= res;
        end
    end

    assign out_vld  = d_vld_reg;
    assign out_data = d_out_reg;

endmodule

`default_nettype wire

// File: sim/triangle_eikonal_stencil_update_test.sv
`timescale 1ns / 1ps

module triangle_eikonal_stencil_update_test;

    localparam int FB = tesu_pkg::FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << FB;
    localparam longint DMAX = 64'h7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    tesu_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    tesu_pkg::out_t out_data;
    logic cfg_write = 1'b0;
    logic [30:0] cfg_data = '0;

    logic [30:0] max_dist_shadow = 31'h7FFF_FFFF;
    tesu_pkg::out_t pending_dist[$];
    int mismatches = 0;
    int sender_gap_max = 15;
    int receiver_gap_max = 15;
    bit long_hold = 1'b0;
    // expected value typed into the table, travels with the driven stimulus
    bit exp_typed = 1'b0;
    tesu_pkg::out_t exp_result = '0;

    typedef struct {
        tesu_pkg::in_t stim;
        bit typed;
        tesu_pkg::out_t result;
    } dir_row_t;

    triangle_eikonal_stencil_update #(.FRAC_BITS(FB)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = longint'(1) << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // local triangle root, returns 1 when the root lies inside the triangle
    function automatic bit solve_triangle(longint w, longint a_in, longint c_in,
                                          longint p, longint q, output longint t);
        longint a, b, c, disc, s, tv, lim, diff;
        longint unsigned sq;
        t = 0;
        a = clamp(a_in, -(longint'(1) << 30), (longint'(1) << 30) - 1);
        b = clamp((w * p) >>> FB, -(longint'(1) << 30), (longint'(1) << 30) - 1);
        sq = longint'(w * w);
        c = clamp(longint'(sq >> FB) + c_in, -(longint'(1) << 30), (longint'(1) << 30) - 1);
        if (a == 0)
            return 1'b0;
        disc = b * b - (2 * a) * (2 * c);
        if (disc < 0)
            return 1'b0;
        s = int_sqrt(disc);
        tv = clamp(((s - b) * ONE) / (2 * a), -(longint'(1) << 31), (longint'(1) << 31) - 1);
        lim = 2 * w * ONE;
        if (!(p * tv <= -lim))
            return 1'b0;
        diff = clamp(tv - w, -(longint'(1) << 31), (longint'(1) << 31) - 1);
        if (!(q * diff <= lim))
            return 1'b0;
        t = tv;
        return 1'b1;
    endfunction

    function automatic tesu_pkg::out_t predict_update(tesu_pkg::in_t x, logic [30:0] maxd);
        longint d1, d2, nd, e, u, t, cand, p_sf, p_fs;
        bit ok;
        tesu_pkg::out_t r;
        d1 = longint'(x.dist_first);
        d2 = longint'(x.dist_second);
        p_sf = longint'($signed(x.coef_second_over_first));
        p_fs = longint'($signed(x.coef_first_over_second));
        nd = longint'(x.current_dist);
        ok = 1'b0;
        e = clamp((x.new_is_first ? d1 : d2) + longint'(x.edge_to_new), 0, DMAX);
        if (e < nd)
            nd = e;
        if (x.either_alive)
        begin
            u = d2 - d1;
            if (u >= 0)
            begin
                ok = solve_triangle(u, longint'($signed(x.quad_a_pos)),
                                    longint'($signed(x.quad_c_pos)), p_sf, p_fs, t);
                cand = d1 + t;
            end
            else
            begin
                ok = solve_triangle(-u, longint'($signed(x.quad_a_neg)),
                                    longint'($signed(x.quad_c_neg)), p_fs, p_sf, t);
                cand = d2 + t;
            end
            cand = ok ? clamp(cand, 0, DMAX) : longint'(maxd);
            if (cand < nd)
                nd = cand;
        end
        r.new_dist = nd[30:0];
        r.triangle_valid = ok;
        return r;
    endfunction

    function automatic tesu_pkg::in_t random_stencil();
        tesu_pkg::in_t x;
        int mode;
        mode = $urandom_range(0, 9);
        x.current_dist = 31'($urandom);
        x.dist_first = 31'($urandom);
        x.dist_second = 31'($urandom);
        x.new_is_first = 1'($urandom);
        x.either_alive = 1'($urandom);
        x.edge_to_new = 31'($urandom);
        x.coef_second_over_first = $signed($urandom);
        x.coef_first_over_second = $signed($urandom);
        x.quad_a_neg = $signed($urandom);
        x.quad_a_pos = $signed($urandom);
        x.quad_c_neg = $signed($urandom);
        x.quad_c_pos = $signed($urandom);
        if (mode < 7)
        begin
            // plausible geometry: small distances, negative cross coefficients
            x.current_dist = 31'($urandom_range(0, 1 << 24));
            x.dist_first = 31'($urandom_range(0, 1 << 21));
            x.dist_second = (mode < 3) ? x.dist_first + 31'($urandom_range(0, 1 << 15))
                                       : 31'($urandom_range(0, 1 << 21));
            x.edge_to_new = 31'($urandom_range(0, 1 << 20));
            x.coef_second_over_first = -$signed($urandom_range(0, 4 << 16));
            x.coef_first_over_second = -$signed($urandom_range(0, 4 << 16));
            x.quad_a_pos = $signed($urandom_range(0, 8 << 16)) - (2 << 16);
            x.quad_a_neg = $signed($urandom_range(0, 8 << 16)) - (2 << 16);
            x.quad_c_pos = $signed($urandom_range(0, 8 << 16)) - (6 << 16);
            x.quad_c_neg = $signed($urandom_range(0, 8 << 16)) - (6 << 16);
            x.either_alive = ($urandom_range(0, 7) != 0);
        end
        return x;
    endfunction

    // result check and expectation capture
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_dist.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: new_dist %h triangle_valid %b",
                             out_data.new_dist, out_data.triangle_valid);
            end
            else
            begin
                tesu_pkg::out_t want;
                want = pending_dist.pop_front();
                if (out_data.new_dist !== want.new_dist ||
                    out_data.triangle_valid !== want.triangle_valid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: new_dist exp %h got %h, triangle_valid exp %b got %b",
                                 want.new_dist, out_data.new_dist,
                                 want.triangle_valid, out_data.triangle_valid);
                end
            end
        end
        if (in_valid && in_ready)
            pending_dist.push_back(exp_typed ? exp_result
                                             : predict_update(in_data, max_dist_shadow));
    end

    // receiver
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = long_hold ? 400 : $urandom_range(0, receiver_gap_max);
            long_hold = 1'b0;
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_stencil(tesu_pkg::in_t x);
        int n;
        n = $urandom_range(0, sender_gap_max);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_data <= x;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_and_write(logic [30:0] v);
        in_valid <= 1'b0;
        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        max_dist_shadow = v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        tesu_pkg::in_t x;
        logic [30:0] settings[5];

        // zero distance, solve disabled
        x = '0;
        row = '{x, 1'b1, '{31'd0, 1'b0}};
        rows.push_back(row);
        // everything at the top, edge path saturates
        x = '1;
        x.either_alive = 1'b0;
        row = '{x, 1'b1, '{tesu_pkg::DIST_MAX, 1'b0}};
        rows.push_back(row);
        // zero leading coefficient, no solution
        x = '0;
        x.current_dist = tesu_pkg::DIST_MAX;
        x.edge_to_new = tesu_pkg::DIST_MAX;
        x.new_is_first = 1'b1;
        x.either_alive = 1'b1;
        x.quad_c_pos = -32'sd65536;
        row = '{x, 1'b1, '{tesu_pkg::DIST_MAX, 1'b0}};
        rows.push_back(row);
        // equal distances, root inside the triangle
        x.quad_a_pos = 32'sd65536;
        x.coef_second_over_first = -32'sd65536;
        x.coef_first_over_second = -32'sd65536;
        row = '{x, 1'b0, '{default: '0}};
        rows.push_back(row);
        // negative discriminant
        x.quad_c_pos = 32'sd65536;
        row = '{x, 1'b0, '{default: '0}};
        rows.push_back(row);
        // swapped branch, second smaller
        x.dist_first = 31'd200000;
        x.dist_second = 31'd100000;
        x.quad_a_neg = 32'sd65536;
        x.quad_c_neg = -32'sd300000;
        x.new_is_first = 1'b0;
        row = '{x, 1'b0, '{default: '0}};
        rows.push_back(row);
        // most negative coefficients, extreme distances
        x = '0;
        x.dist_second = tesu_pkg::DIST_MAX;
        x.current_dist = tesu_pkg::DIST_MAX;
        x.either_alive = 1'b1;
        x.coef_second_over_first = 32'h8000_0000;
        x.coef_first_over_second = 32'h8000_0000;
        x.quad_a_pos = 32'h8000_0000;
        x.quad_c_pos = 32'h8000_0000;
        row = '{x, 1'b0, '{default: '0}};
        rows.push_back(row);
        x.quad_a_pos = 32'h7FFF_FFFF;
        x.quad_c_pos = 32'h7FFF_FFFF;
        x.coef_second_over_first = 32'h7FFF_FFFF;
        row = '{x, 1'b0, '{default: '0}};
        rows.push_back(row);
        x.dist_first = tesu_pkg::DIST_MAX;
        x.dist_second = '0;
        x.quad_a_neg = 32'h8000_0000;
        x.quad_c_neg = 32'h7FFF_FFFF;
        row = '{x, 1'b0, '{default: '0}};
        rows.push_back(row);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            exp_typed <= rows[i].typed;
            exp_result <= rows[i].result;
            in_data <= rows[i].stim;
            in_valid <= 1'b1;
            do @(posedge clk); while (!in_ready);
            in_valid <= 1'b0;
            exp_typed <= 1'b0;
            @(posedge clk);
        end

        settings[0] = 31'd0;
        settings[1] = 31'h7FFF_FFFF;
        settings[2] = 31'($urandom);
        settings[3] = 31'($urandom_range(0, 1 << 22));
        settings[4] = 31'h7FFF_FFFF;
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_and_write(settings[ph]);
            sender_gap_max = (ph == 1) ? 0 : 15;
            receiver_gap_max = (ph == 1) ? 0 : 15;
            if (ph == 2)
                long_hold = 1'b1;
            for (int k = 0; k < 350; k++)
                send_stencil(random_stencil());
        end
        in_valid <= 1'b0;

        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
